>>> design/ps2mct_pkg.sv
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker package
// Shared types and constants for the cursor tracker, its core and checker.
// ----------------------------------------------------------------------------
package ps2mct_pkg;

    // Configuration port geometry
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Field widths
    localparam int SCREEN_W  = 13;
    localparam int CSIZE_W   = 7;
    localparam int POS_W     = 12;
    localparam int BTN_W     = 3;
    localparam int WHEEL_W   = 8;
    localparam int OP_W      = 2;
    localparam int BYTE_W    = 8;

    // Reset values of the configuration and cursor state
    localparam logic [SCREEN_W-1:0] SCREEN_W_RST    = 13'd320;
    localparam logic [SCREEN_W-1:0] SCREEN_H_RST    = 13'd200;
    localparam logic [CSIZE_W-1:0]  SPRITE_SIZE_RST = 7'd8;
    localparam logic [POS_W-1:0]    POS_X_RST       = 12'd160;
    localparam logic [POS_W-1:0]    POS_Y_RST       = 12'd100;

    // Packet decode constants
    localparam int START_BIT     = 3;
    localparam int DX_SIGN_BIT   = 4;
    localparam int DY_SIGN_BIT   = 5;
    localparam int DELTA_LIMIT   = 12;
    localparam int WHEEL_LIMIT   = 64;
    localparam int POS_MAX       = 4095;

    // Operation codes of an input beat
    typedef enum logic [1:0] {
        OP_DATA       = 2'd0,
        OP_TAKE_WHEEL = 2'd1,
        OP_CLR_BTN    = 2'd2,
        OP_RECENTRE   = 2'd3
    } t_op;

    // Register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_SCREEN_W    = 2'd0,
        REG_SCREEN_H    = 2'd1,
        REG_SPRITE_SIZE = 2'd2,
        REG_WHEEL_MODE  = 2'd3
    } t_reg_idx;

    // Position of the next byte inside a packet
    typedef enum logic [1:0] {
        PH_HEAD  = 2'd0,
        PH_DX    = 2'd1,
        PH_DY    = 2'd2,
        PH_WHEEL = 2'd3
    } t_phase;

    // Configuration bundle handed to the core
    typedef struct packed {
        logic [SCREEN_W-1:0] screen_width;
        logic [SCREEN_W-1:0] screen_height;
        logic [CSIZE_W-1:0]  sprite_size;
        logic                wheel_mode;
    } t_cfg;

    // One input beat
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] data_byte;
        logic              from_aux;
    } t_in_beat;

    // One result beat
    typedef struct packed {
        logic [POS_W-1:0]          cursor_x;
        logic [POS_W-1:0]          cursor_y;
        logic [BTN_W-1:0]          buttons;
        logic signed [WHEEL_W-1:0] wheel_total;
        logic                      packet_done;
        logic                      packet_dropped;
    } t_result;

endpackage

>>> design/ps2mct_if.sv
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker channels
// Valid/ready interfaces for the input byte channel and the result channel.
// ----------------------------------------------------------------------------

// Input channel: one operation or received byte per beat.
interface ps2mct_in_if
    import ps2mct_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] data_byte;
    logic              from_aux;

    modport source (output valid, output op, output data_byte, output from_aux,
                    input ready);
    modport sink   (input valid, input op, input data_byte, input from_aux,
                    output ready);
endinterface

// Result channel: cursor state and packet flags per beat.
interface ps2mct_out_if
    import ps2mct_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [POS_W-1:0]          cursor_x;
    logic [POS_W-1:0]          cursor_y;
    logic [BTN_W-1:0]          buttons;
    logic signed [WHEEL_W-1:0] wheel_total;
    logic                      packet_done;
    logic                      packet_dropped;

    modport source (output valid, output cursor_x, output cursor_y, output buttons,
                    output wheel_total, output packet_done, output packet_dropped,
                    input ready);
    modport sink   (input valid, input cursor_x, input cursor_y, input buttons,
                    input wheel_total, input packet_done, input packet_dropped,
                    output ready);
endinterface

>>> design/ps2mct_core.sv
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker core
// Holds the packet and cursor state and computes one result per beat.
// ----------------------------------------------------------------------------
module ps2mct_core
    import ps2mct_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_adv,
    input  t_in_beat i_beat,
    input  t_cfg     i_cfg,
    output t_result  o_result
);

    // Clamp a 9-bit movement delta to the allowed step.
    function automatic logic signed [4:0] clamp_delta(input logic signed [8:0] v);
        logic signed [4:0] res;
        if (v > 9'(DELTA_LIMIT)) begin
            res = 5'(DELTA_LIMIT);
        end else if (v < -9'(DELTA_LIMIT)) begin
            res = -5'(DELTA_LIMIT);
        end else begin
            res = v[4:0];
        end
        return res;
    endfunction

    // Bound a moved position to the screen minus the cursor size.
    function automatic logic [POS_W-1:0] bound_pos(input logic signed [13:0] p,
                                                   input logic [SCREEN_W-1:0] size,
                                                   input logic [CSIZE_W-1:0] csz);
        logic signed [14:0] lim;
        logic [POS_W-1:0]   lim_c;
        logic [POS_W-1:0]   res;
        lim = $signed({2'b00, size}) - $signed({8'b0, csz}) - 15'sd1;
        if (lim < 15'sd0) begin
            lim_c = '0;
        end else if (lim > 15'(POS_MAX)) begin
            lim_c = POS_W'(POS_MAX);
        end else begin
            lim_c = lim[POS_W-1:0];
        end
        if (p < 14'sd0) begin
            res = '0;
        end else if (p > $signed({2'b00, lim_c})) begin
            res = lim_c;
        end else begin
            res = p[POS_W-1:0];
        end
        return res;
    endfunction

    t_phase                    r_phase, n_phase;
    logic [7:0]                r_pkt [3];
    logic [POS_W-1:0]          r_pos_x, n_pos_x;
    logic [POS_W-1:0]          r_pos_y, n_pos_y;
    logic [BTN_W-1:0]          r_buttons, n_buttons;
    logic signed [WHEEL_W-1:0] r_wheel, n_wheel;

    t_op                       op;
    logic [7:0]                b;
    logic                      is_byte;
    logic                      complete;
    logic                      has_wheel;
    logic                      overflow;
    logic [7:0]                head;
    logic [7:0]                dy_byte;
    logic signed [4:0]         dx;
    logic signed [4:0]         dy;
    logic signed [13:0]        sum_x;
    logic signed [13:0]        sum_y;
    logic signed [8:0]         wheel_sum;
    logic signed [WHEEL_W-1:0] wheel_sat;
    logic                      done;
    logic                      dropped;

    assign op      = t_op'(i_beat.op);
    assign b       = i_beat.data_byte;
    assign is_byte = (op == OP_DATA) && i_beat.from_aux;

    // Packet completion: third byte in 3-byte mode, or the wheel byte.
    assign has_wheel = (r_phase == PH_WHEEL);
    assign complete  = is_byte && (has_wheel || (r_phase == PH_DY && !i_cfg.wheel_mode));
    assign head      = r_pkt[0];
    assign overflow  = |head[7:6];
    assign done      = complete && !overflow;
    assign dropped   = complete && overflow;

    // Movement deltas as 9-bit two's complement, clamped.
    assign dy_byte = has_wheel ? r_pkt[2] : b;
    assign dx      = clamp_delta($signed({head[DX_SIGN_BIT], r_pkt[1]}));
    assign dy      = clamp_delta($signed({head[DY_SIGN_BIT], dy_byte}));
    assign sum_x   = $signed({2'b00, r_pos_x}) + $signed({{9{dx[4]}}, dx});
    assign sum_y   = $signed({2'b00, r_pos_y}) - $signed({{9{dy[4]}}, dy});

    // Wheel accumulation with saturation.
    assign wheel_sum = $signed({r_wheel[WHEEL_W-1], r_wheel}) + $signed({b[7], b});
    always_comb begin
        if (wheel_sum > 9'(WHEEL_LIMIT)) begin
            wheel_sat = WHEEL_W'(WHEEL_LIMIT);
        end else if (wheel_sum < -9'(WHEEL_LIMIT)) begin
            wheel_sat = -WHEEL_W'(WHEEL_LIMIT);
        end else begin
            wheel_sat = wheel_sum[WHEEL_W-1:0];
        end
    end

    // Next state for every operation.
    always_comb begin
        n_phase   = r_phase;
        n_pos_x   = r_pos_x;
        n_pos_y   = r_pos_y;
        n_buttons = r_buttons;
        n_wheel   = r_wheel;
        case (op)
            OP_DATA: begin
                if (i_beat.from_aux) begin
                    case (r_phase)
                        PH_HEAD: begin
                            if (b[START_BIT]) begin
                                n_phase = PH_DX;
                            end
                        end
                        PH_DX: begin
                            n_phase = PH_DY;
                        end
                        PH_DY: begin
                            n_phase = i_cfg.wheel_mode ? PH_WHEEL : PH_HEAD;
                        end
                        default: begin
                            n_phase = PH_HEAD;
                        end
                    endcase
                end
                if (done) begin
                    n_buttons = head[BTN_W-1:0];
                    n_pos_x   = bound_pos(sum_x, i_cfg.screen_width, i_cfg.sprite_size);
                    n_pos_y   = bound_pos(sum_y, i_cfg.screen_height, i_cfg.sprite_size);
                    if (has_wheel) begin
                        n_wheel = wheel_sat;
                    end
                end
            end
            OP_TAKE_WHEEL: begin
                n_wheel = '0;
            end
            OP_CLR_BTN: begin
                n_buttons = '0;
            end
            OP_RECENTRE: begin
                n_pos_x = i_cfg.screen_width[SCREEN_W-1:1];
                n_pos_y = i_cfg.screen_height[SCREEN_W-1:1];
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    // Control and cursor state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEAD;
            r_pos_x   <= POS_X_RST;
            r_pos_y   <= POS_Y_RST;
            r_buttons <= '0;
            r_wheel   <= '0;
        end else if (i_adv) begin
            r_phase   <= n_phase;
            r_pos_x   <= n_pos_x;
            r_pos_y   <= n_pos_y;
            r_buttons <= n_buttons;
            r_wheel   <= n_wheel;
        end
    end

    // Packet byte store; each entry is written before its packet reads it.
    always_ff @(posedge i_clk) begin
        if (i_adv && is_byte) begin
            if (r_phase == PH_HEAD && b[START_BIT]) begin
                r_pkt[0] <= b;
            end
            if (r_phase == PH_DX) begin
                r_pkt[1] <= b;
            end
            if (r_phase == PH_DY) begin
                r_pkt[2] <= b;
            end
        end
    end

    // Result fields; a take reports the total before it is cleared.
    always_comb begin
        o_result.cursor_x       = n_pos_x;
        o_result.cursor_y       = n_pos_y;
        o_result.buttons        = n_buttons;
        o_result.wheel_total    = (op == OP_TAKE_WHEEL) ? r_wheel : n_wheel;
        o_result.packet_done    = done;
        o_result.packet_dropped = dropped;
    end

endmodule

>>> design/ps2_mouse_cursor_tracker.sv
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker
// Decodes PS/2 mouse packets into a clamped cursor, buttons and wheel total.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one beat per operation: a received controller byte with its
//   port flag, or a command to take the wheel total, clear the buttons or
//   recentre the cursor. o_out returns exactly one result beat per input
//   beat, in order, with the cursor, buttons, wheel total and packet flags.
//   The APB port sets screen width, screen height, cursor size and the
//   wheel packet mode; write it only while no beat is in flight.
// Pipeline and throughput:
//   A beat is registered at the input, decoded in one pass against the held
//   cursor state, and its result registered in the result register. One
//   beat is taken every cycle while o_out is not stalled; the single pass
//   through the cursor state sets that rate.
// Reset:
//   Synchronous reset empties both stages, restores the default screen and
//   recentres the cursor at 160,100 with buttons and wheel cleared.
// Stall:
//   While o_out is stalled the result holds; the input stage fills once and
//   then i_in.ready drops until the result beat is taken.
// ----------------------------------------------------------------------------
module ps2_mouse_cursor_tracker
    import ps2mct_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ps2mct_in_if.sink             i_in,
    ps2mct_out_if.source          o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     cfg_wr;

    logic     r_in_valid;
    t_in_beat r_in;
    logic     r_out_valid;
    t_result  r_out;
    t_result  core_result;
    logic     adv;
    logic     in_take;

    // Configuration registers
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screen_width  <= SCREEN_W_RST;
            r_cfg.screen_height <= SCREEN_H_RST;
            r_cfg.sprite_size   <= SPRITE_SIZE_RST;
            r_cfg.wheel_mode    <= 1'b0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_SCREEN_W:    r_cfg.screen_width  <= pwdata[SCREEN_W-1:0];
                REG_SCREEN_H:    r_cfg.screen_height <= pwdata[SCREEN_W-1:0];
                REG_SPRITE_SIZE: r_cfg.sprite_size   <= pwdata[CSIZE_W-1:0];
                REG_WHEEL_MODE:  r_cfg.wheel_mode    <= pwdata[0];
                default:         r_cfg.wheel_mode    <= r_cfg.wheel_mode;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (reg_idx)
            REG_SCREEN_W:    prdata = APB_DATA_W'(r_cfg.screen_width);
            REG_SCREEN_H:    prdata = APB_DATA_W'(r_cfg.screen_height);
            REG_SPRITE_SIZE: prdata = APB_DATA_W'(r_cfg.sprite_size);
            REG_WHEEL_MODE:  prdata = APB_DATA_W'(r_cfg.wheel_mode);
            default:         prdata = '0;
        endcase
    end

    // Stage handshake: the input stage moves on when the result slot frees.
    assign adv        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || adv;
    assign in_take    = i_in.valid && i_in.ready;

    // Input beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.op        <= i_in.op;
            r_in.data_byte <= i_in.data_byte;
            r_in.from_aux  <= i_in.from_aux;
        end
    end

    // Decode and cursor state
    ps2mct_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_beat   (r_in),
        .i_cfg    (r_cfg),
        .o_result (core_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= core_result;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.cursor_x       = r_out.cursor_x;
    assign o_out.cursor_y       = r_out.cursor_y;
    assign o_out.buttons        = r_out.buttons;
    assign o_out.wheel_total    = r_out.wheel_total;
    assign o_out.packet_done    = r_out.packet_done;
    assign o_out.packet_dropped = r_out.packet_dropped;

endmodule

>>> design/ps2mct_checker.sv
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module ps2mct_checker
    import ps2mct_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [POS_W-1:0]          i_cursor_x,
    input logic [POS_W-1:0]          i_cursor_y,
    input logic [BTN_W-1:0]          i_buttons,
    input logic signed [WHEEL_W-1:0] i_wheel_total,
    input logic                      i_packet_done,
    input logic                      i_packet_dropped
);

    // A packet is either applied or discarded, never both.
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_packet_done && i_packet_dropped))
        else $error("packet applied and dropped on the same beat");

    // The wheel total stays within its saturation range.
    a_wheel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_wheel_total <= 8'sd64) && (i_wheel_total >= -8'sd64))
        else $error("wheel total outside saturation range");

    // Reset leaves no result beat pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat present after reset");

    // A stalled result beat holds.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid && $stable(i_cursor_x)
            && $stable(i_cursor_y) && $stable(i_buttons) && $stable(i_wheel_total)
            && $stable(i_packet_done) && $stable(i_packet_dropped))
        else $error("stalled result beat changed");

endmodule

bind ps2_mouse_cursor_tracker ps2mct_checker u_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_cursor_x       (o_out.cursor_x),
    .i_cursor_y       (o_out.cursor_y),
    .i_buttons        (o_out.buttons),
    .i_wheel_total    (o_out.wheel_total),
    .i_packet_done    (o_out.packet_done),
    .i_packet_dropped (o_out.packet_dropped)
);
